[rtl/iir_controller_with_saturation_defines.svh]
// Assertion macros for the IIR controller with output limiting
`ifndef IIR_CONTROLLER_WITH_SATURATION_DEFINES_SVH
`define IIR_CONTROLLER_WITH_SATURATION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IIRCS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IIRCS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/iircs_pkg.sv]
// Package: constants, types and saturation helpers for the IIR controller
`default_nettype none

package iircs_pkg;

  localparam int unsigned ORDER     = 2;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DCNT_W    = 6;

  typedef enum logic [2:0] {
    REG_GAIN  = 3'd0,
    REG_B0    = 3'd1,
    REG_B1    = 3'd2,
    REG_B2    = 3'd3,
    REG_A0    = 3'd4,
    REG_A1    = 3'd5,
    REG_A2    = 3'd6,
    REG_LIMIT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]       gain;
    logic [2:0][31:0]  coef_b;
    logic [30:0]       coef_a0;
    logic [2:1][31:0]  coef_a;
    logic [14:0]       lim;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_TERM,
    ST_ACC,
    ST_FB,
    ST_SUB,
    ST_DIV,
    ST_DIVW,
    ST_FIN
  } state_t;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // floor shift right by 16, then clamp to 32 bits
  function automatic logic [31:0] sat_sh16(input logic [63:0] p);
    logic [47:0] s;
    s = p[63:16];
    if (s[47:31] == {17{1'b0}} || s[47:31] == {17{1'b1}}) begin
      return s[31:0];
    end else if (s[47]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  // clamp a 33-bit sum to 32 bits
  function automatic logic [31:0] sat_sum(input logic [32:0] s);
    if (s[32] == s[31]) begin
      return s[31:0];
    end else if (s[32]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/iircs_regs.sv]
// Configuration register file: gain, coefficients and output limit
`default_nettype none

module iircs_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_idx,
  input  wire logic [31:0]        wr_data,
  output iircs_pkg::cfg_t         cfg
);
  import iircs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= 32'h0001_0000;
      cfg_r.coef_b[0] <= 32'h0001_0000;
      cfg_r.coef_b[1] <= '0;
      cfg_r.coef_b[2] <= '0;
      cfg_r.coef_a0   <= 31'h0001_0000;
      cfg_r.coef_a[1] <= '0;
      cfg_r.coef_a[2] <= '0;
      cfg_r.lim       <= 15'd4096;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_GAIN:  cfg_r.gain      <= wr_data;
        REG_B0:    cfg_r.coef_b[0] <= wr_data;
        REG_B1:    cfg_r.coef_b[1] <= wr_data;
        REG_B2:    cfg_r.coef_b[2] <= wr_data;
        REG_A0:    cfg_r.coef_a0   <= wr_data[30:0];
        REG_A1:    cfg_r.coef_a[1] <= wr_data;
        REG_A2:    cfg_r.coef_a[2] <= wr_data;
        REG_LIMIT: cfg_r.lim       <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/iircs_mul.sv]
// Shared signed 32x32 multiplier with registered product and Q16 rescale
`default_nettype none

module iircs_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic [31:0]      res
);
  import iircs_pkg::*;

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'($signed(op_a) * $signed(op_b));
    end
  end

  assign res = sat_sh16(prod_r);

endmodule

`default_nettype wire

[rtl/iircs_div.sv]
// Restoring divider, one quotient bit per cycle
`default_nettype none

module iircs_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [30:0] divisor,
  output logic             done,
  output logic [47:0]      quotient
);
  import iircs_pkg::*;

  logic [47:0]       dvd_r, dvd_nxt;
  logic [30:0]       rem_r, rem_nxt;
  logic [30:0]       dsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [31:0]       trial;
  logic [31:0]       diff;
  logic              ge;

  always_comb begin
    trial   = {rem_r, dvd_r[47]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[30:0] : trial[30:0];
    dvd_nxt = {dvd_r[46:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

[rtl/iir_controller_with_saturation.sv]
// Top level: sequencer, histories and output limiting of the IIR controller
// Sequence: gain, term and accumulate states per feed-forward term, then
// feedback and subtract states per feedback term, the divider and ST_FIN.
// Throughput: a new item is accepted only in ST_IDLE, once the last one has
// passed the bit-serial 48-step divider and the single shared multiplier.
// Reset: synchronous active-low rst_n restores register defaults and zeroes
// both histories; in_tready is high as soon as reset is released.
`default_nettype none
`include "iir_controller_with_saturation_defines.svh"

module iir_controller_with_saturation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] error_in
  input  wire logic        in_tuser,   // [0] clear_hist
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] drive_out
  output logic             out_tuser,  // [0] clipped
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import iircs_pkg::*;

  cfg_t              cfg;
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [15:0]       x0_r, x0_nxt;
  logic [15:0]       pe0_r, pe0_nxt, pe1_r, pe1_nxt;
  logic [31:0]       po0_r, po0_nxt, po1_r, po1_nxt;
  logic [31:0]       y_r, y_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_drive_r, out_drive_nxt;
  logic              out_clip_r, out_clip_nxt;

  logic              in_fire;
  logic              mul_en;
  logic [31:0]       mul_a, mul_b, mul_res;
  logic              div_start, div_done;
  logic [47:0]       div_quo;
  logic [31:0]       acc_mag;
  logic [30:0]       div_dsr;
  logic [15:0]       x_sel;
  logic [31:0]       lim32;
  logic signed [16:0] lim_s;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  iircs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  iircs_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  assign acc_mag = acc_r[31] ? (32'd0 - acc_r) : acc_r;
  assign div_dsr = (cfg.coef_a0 == '0) ? 31'd1 : cfg.coef_a0;

  iircs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({acc_mag, 16'h0000}),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign lim32 = {17'd0, cfg.lim};
  assign lim_s = {2'b00, cfg.lim};

  always_comb begin
    case (idx_r)
      2'd0:    x_sel = x0_r;
      2'd1:    x_sel = pe0_r;
      default: x_sel = pe1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pe0_r       <= '0;
      pe1_r       <= '0;
      po0_r       <= '0;
      po1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pe0_r       <= pe0_nxt;
      pe1_r       <= pe1_nxt;
      po0_r       <= po0_nxt;
      po1_r       <= po1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    x0_r        <= x0_nxt;
    y_r         <= y_nxt;
    neg_r       <= neg_nxt;
    out_drive_r <= out_drive_nxt;
    out_clip_r  <= out_clip_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    x0_nxt        = x0_r;
    pe0_nxt       = pe0_r;
    pe1_nxt       = pe1_r;
    po0_nxt       = po0_r;
    po1_nxt       = po1_r;
    y_nxt         = y_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_drive_nxt = out_drive_r;
    out_clip_nxt  = out_clip_r;
    mul_en        = 1'b0;
    mul_a         = cfg.gain;
    mul_b         = cfg.coef_b[0];
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x0_nxt  = in_tdata;
          acc_nxt = '0;
          idx_nxt = '0;
          if (in_tuser) begin
            pe0_nxt = '0;
            pe1_nxt = '0;
            po0_nxt = '0;
            po1_nxt = '0;
          end
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        mul_en = 1'b1;
        mul_a  = cfg.gain;
        case (idx_r)
          2'd0:    mul_b = cfg.coef_b[0];
          2'd1:    mul_b = cfg.coef_b[1];
          default: mul_b = cfg.coef_b[2];
        endcase
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        mul_en    = 1'b1;
        mul_a     = mul_res;
        mul_b     = {{16{x_sel[15]}}, x_sel};
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = sat_sum({acc_r[31], acc_r} + {mul_res[31], mul_res});
        if (idx_r == IDX_W'(ORDER)) begin
          idx_nxt   = IDX_W'(1);
          state_nxt = ST_FB;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_GAIN;
        end
      end
      ST_FB: begin
        mul_en = 1'b1;
        if (idx_r == IDX_W'(1)) begin
          mul_a = cfg.coef_a[1];
          mul_b = po0_r;
        end else begin
          mul_a = cfg.coef_a[2];
          mul_b = po1_r;
        end
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        acc_nxt = sat_sum({acc_r[31], acc_r} - {mul_res[31], mul_res});
        if (idx_r == IDX_W'(ORDER)) begin
          state_nxt = ST_DIV;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_FB;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        neg_nxt   = acc_r[31];
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          if (!neg_r) begin
            y_nxt = (div_quo[47:31] != '0) ? SAT_MAX : div_quo[31:0];
          end else if (div_quo[47:32] != '0 || (div_quo[31] && div_quo[30:0] != '0)) begin
            y_nxt = SAT_MIN;
          end else begin
            y_nxt = 32'd0 - div_quo[31:0];
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if ($signed(y_r) > $signed(lim32)) begin
            out_drive_nxt = {1'b0, cfg.lim};
            out_clip_nxt  = 1'b1;
          end else if ($signed(y_r) < -$signed(lim32)) begin
            out_drive_nxt = 16'd0 - {1'b0, cfg.lim};
            out_clip_nxt  = 1'b1;
          end else begin
            out_drive_nxt = y_r[15:0];
            out_clip_nxt  = 1'b0;
          end
          pe1_nxt   = pe0_r;
          pe0_nxt   = x0_r;
          po1_nxt   = po0_r;
          po0_nxt   = y_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_clip_r;

  `IIRCS_ASSERT_NXT(a_accept_starts, in_fire, state_r == ST_GAIN,
    "accepted item did not start the sequencer")
  `IIRCS_ASSERT_IMP(a_unclipped_in_range, out_valid_r && !out_clip_r,
    $signed(out_drive_r) <= lim_s && $signed(out_drive_r) >= -lim_s,
    "unclipped drive outside the limit")
  `IIRCS_ASSERT_IMP(a_clipped_at_limit, out_valid_r && out_clip_r,
    $signed(out_drive_r) == lim_s || $signed(out_drive_r) == -lim_s,
    "clipped drive not at the limit")
  `IIRCS_ASSERT_IMP(a_div_done_waiting, div_done, state_r == ST_DIVW,
    "divider finished outside its wait state")

endmodule

`default_nettype wire

[tb/sv/iir_controller_with_saturation_tb.sv]
// Testbench: IIR controller with output limiting, checked item by item against a local predictor
`timescale 1ns / 100ps

module iir_controller_with_saturation_tb;
  import iircs_pkg::*;

  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          DRAIN_CYCLES = 70;
  localparam int          SETTINGS_PER_PHASE = 6;
  localparam int          ITEMS_PER_SETTING = 90;
  localparam longint      MAX32 = 2147483647;
  localparam longint      MIN32 = -longint'(2147483647) - 1;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_FIXED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] data;
    logic [15:0] err;
    logic        clr;
    logic [15:0] drv;
    logic        clp;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] drive;
    logic        clip;
  } drive_exp_t;

  typedef struct {
    int          gain;
    int          b [3];
    logic [30:0] a0;
    int          a [3];
    logic [14:0] lim;
  } ctrl_setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ctrl_setting_t ctrl;
  shortint       err_hist [2];
  int            y_hist [2];
  drive_exp_t    pending_drive [$];
  int            fails = 0;
  int            cycles = 0;
  int            send_idle_pct = 9;
  int            recv_idle_pct = 78;

  plan_row_t plan [$] = '{
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h0064, 1'b0, 16'h0064, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h7FFF, 1'b0, 16'h1000, 1'b1},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h8000, 1'b0, 16'hF000, 1'b1},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h1000, 1'b0, 16'h1000, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'hF000, 1'b0, 16'hF000, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h1001, 1'b0, 16'h1000, 1'b1},
    '{ROW_CFG,   REG_LIMIT, 32'hFFFF_8000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h0005, 1'b0, 16'h0000, 1'b1},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'hFFFF, 1'b0, 16'h0000, 1'b1},
    '{ROW_CFG,   REG_LIMIT, 32'h0000_7FFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h8000, 1'b0, 16'h8001, 1'b1},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h7FFF, 1'b0, 16'h7FFF, 1'b0},
    '{ROW_CFG,   REG_A0,    32'h8000_0000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h0001, 1'b0, 16'h7FFF, 1'b1},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_FIXED, REG_GAIN,  32'h0, 16'hFFFF, 1'b0, 16'h8001, 1'b1},
    '{ROW_CFG,   REG_GAIN,  32'h7FFF_FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_B0,    32'h8000_0000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_B1,    32'h7FFF_FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_B2,    32'hFFFF_0000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_A0,    32'hFFFF_FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_A1,    32'h8000_0000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_A2,    32'h7FFF_FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_LIMIT, 32'h0000_4000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h7FFF, 1'b1, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h8000, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h3039, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h8000, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h7FFF, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_GAIN,  32'h0001_0000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_B0,    32'h0000_8000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_B1,    32'h0000_4000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_B2,    32'hFFFF_E000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_A0,    32'h0001_0000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_A1,    32'hFFFF_8000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_A2,    32'h0000_4000, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,   REG_LIMIT, 32'h0000_1F40, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h0800, 1'b1, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h0800, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h0800, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'hF800, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM,  REG_GAIN,  32'h0, 16'h0000, 1'b1, 16'h0, 1'b0}
  };

  iir_controller_with_saturation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] error_in
    .in_tuser   (in_tuser),   // [0] clear_hist
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] drive_out
    .out_tuser  (out_tuser),  // [0] clipped
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp32(input longint v);
    if (v > MAX32) begin
      return int'(MAX32);
    end else if (v < MIN32) begin
      return int'(MIN32);
    end
    return int'(v);
  endfunction

  function automatic void reset_controller();
    ctrl.gain = 65536;
    ctrl.b[0] = 65536;
    ctrl.b[1] = 0;
    ctrl.b[2] = 0;
    ctrl.a0   = 31'd65536;
    ctrl.a[0] = 0;
    ctrl.a[1] = 0;
    ctrl.a[2] = 0;
    ctrl.lim  = 15'd4096;
    err_hist  = '{0, 0};
    y_hist    = '{0, 0};
  endfunction

  function automatic void store_setting(input reg_idx_t idx, input logic [31:0] d);
    case (idx)
      REG_GAIN:  ctrl.gain = d;
      REG_B0:    ctrl.b[0] = d;
      REG_B1:    ctrl.b[1] = d;
      REG_B2:    ctrl.b[2] = d;
      REG_A0:    ctrl.a0   = d[30:0];
      REG_A1:    ctrl.a[1] = d;
      REG_A2:    ctrl.a[2] = d;
      REG_LIMIT: ctrl.lim  = d[14:0];
      default: ;
    endcase
  endfunction

  // one controller step: difference equation, divide by a0, clamp to the limit
  function automatic drive_exp_t next_drive(input logic [15:0] err, input logic clr);
    shortint    xs [3];
    int         g;
    int         t;
    int         f;
    int         acc;
    int         y;
    int         lim;
    longint     dv;
    drive_exp_t r;
    if (clr) begin
      err_hist = '{0, 0};
      y_hist   = '{0, 0};
    end
    xs[0] = err;
    xs[1] = err_hist[0];
    xs[2] = err_hist[1];
    acc = 0;
    for (int i = 0; i <= ORDER; i++) begin
      g = clamp32((longint'(ctrl.gain) * longint'(ctrl.b[i])) >>> 16);
      t = clamp32((longint'(g) * longint'(xs[i])) >>> 16);
      acc = clamp32(longint'(acc) + longint'(t));
    end
    for (int j = 1; j <= ORDER; j++) begin
      f = clamp32((longint'(ctrl.a[j]) * longint'(y_hist[j - 1])) >>> 16);
      acc = clamp32(longint'(acc) - longint'(f));
    end
    dv = (ctrl.a0 == '0) ? 64'sd1 : longint'({33'd0, ctrl.a0});
    y = clamp32((longint'(acc) * 65536) / dv);
    lim = int'({17'd0, ctrl.lim});
    r.clip = 1'b0;
    r.drive = y[15:0];
    if (y > lim) begin
      r.drive = lim[15:0];
      r.clip = 1'b1;
    end else if (y < -lim) begin
      r.drive = 16'(-lim);
      r.clip = 1'b1;
    end
    err_hist[1] = err_hist[0];
    err_hist[0] = xs[0];
    y_hist[1] = y_hist[0];
    y_hist[0] = y;
    return r;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_setting(idx, d);
  endtask

  task automatic send_error(input logic [15:0] err, input logic clr, input logic fixed,
                            input logic [15:0] drv, input logic clp);
    drive_exp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= err;
    in_tuser  <= clr;
    do @(posedge clk); while (!in_tready);
    p = next_drive(err, clr);
    if (fixed) begin
      p.drive = drv;
      p.clip  = clp;
    end
    pending_drive.push_back(p);
  endtask

  task automatic load_setting();
    logic [31:0] lim_word;
    lim_word = $urandom;
    lim_word[14:0] = 15'($urandom_range(32767));
    if ($urandom_range(4) == 0) begin
      write_reg(REG_GAIN, $urandom);
      write_reg(REG_B0, $urandom);
      write_reg(REG_B1, $urandom);
      write_reg(REG_B2, $urandom);
      write_reg(REG_A0, $urandom);
      write_reg(REG_A1, $urandom);
      write_reg(REG_A2, $urandom);
    end else begin
      write_reg(REG_GAIN, 32'(int'($urandom_range(262144)) - 131072));
      write_reg(REG_B0, 32'(int'($urandom_range(262144)) - 131072));
      write_reg(REG_B1, 32'(int'($urandom_range(262144)) - 131072));
      write_reg(REG_B2, 32'(int'($urandom_range(262144)) - 131072));
      write_reg(REG_A0, ($urandom_range(15) == 0) ? 32'h0 : $urandom_range(262144, 16384));
      write_reg(REG_A1, 32'(int'($urandom_range(65536)) - 32768));
      write_reg(REG_A2, 32'(int'($urandom_range(65536)) - 32768));
    end
    write_reg(REG_LIMIT, lim_word);
  endtask

  always @(posedge clk) begin
    drive_exp_t e;
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected result: drive_out %0d clipped %0b", $signed(out_tdata), out_tuser);
        fails++;
      end else begin
        e = pending_drive.pop_front();
        if (out_tdata !== e.drive) begin
          $error("drive_out: expected %0d, got %0d", $signed(e.drive), $signed(out_tdata));
          fails++;
        end
        if (out_tuser !== e.clip) begin
          $error("clipped: expected %0b, got %0b", e.clip, out_tuser);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [15:0] err;
    reset_controller();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      case (plan[k].kind)
        ROW_CFG:   write_reg(plan[k].idx, plan[k].data);
        ROW_ITEM:  send_error(plan[k].err, plan[k].clr, 1'b0, '0, 1'b0);
        ROW_FIXED: send_error(plan[k].err, plan[k].clr, 1'b1, plan[k].drv, plan[k].clp);
        default: ;
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        load_setting();
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          err = ($urandom_range(3) == 0) ? 16'($urandom)
                                         : 16'(int'($urandom_range(4096)) - 2048);
          send_error(err, ($urandom_range(24) == 0), 1'b0, '0, 1'b0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/iircs_pkg.sv
rtl/iircs_regs.sv
rtl/iircs_mul.sv
rtl/iircs_div.sv
rtl/iir_controller_with_saturation.sv
tb/sv/iir_controller_with_saturation_tb.sv
